// File: hdl/ctp_pkg.sv
// ---------------------------------------------------------------------------
// ctp_pkg
// Shared types, constants and helpers of the clock timestamp text parser.
// ---------------------------------------------------------------------------
package ctp_pkg;

  localparam int FIELD_WIDTH_DEF = 16;
  localparam int CHAR_W          = 8;
  localparam int TIME_W          = 42;
  localparam int FRAC_W          = 10;
  localparam int FDIG_W          = 2;
  localparam int FRAC_US_W       = 20;
  localparam int FRAC_KEEP       = 3;
  localparam int SEC_PER_MIN     = 60;
  localparam int US_PER_S        = 1000000;
  localparam int US_PER_MS       = 1000;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_COLON  = 3'd1,
    ERR_BAD_CHAR  = 3'd2,
    ERR_EMPTY_SEC = 3'd3,
    ERR_EMPTY_FRC = 3'd4,
    ERR_OVERFLOW  = 3'd5
  } err_t;

  // first structural error wins; overflow yields to a later structural one
  function automatic err_t latch_err(input err_t cur, input err_t code);
    err_t res;
    res = cur;
    if (cur == ERR_NONE || (cur == ERR_OVERFLOW && code != ERR_OVERFLOW)) begin
      res = code;
    end
    return res;
  endfunction

  // fraction value to microseconds, padded by digit count
  function automatic logic [FRAC_US_W-1:0] frac_scale_us(input logic [FDIG_W-1:0] n);
    logic [FRAC_US_W-1:0] s;
    unique case (n)
      2'd1:    s = FRAC_US_W'(100 * US_PER_MS);
      2'd2:    s = FRAC_US_W'(10 * US_PER_MS);
      default: s = FRAC_US_W'(US_PER_MS);
    endcase
    return s;
  endfunction

endpackage

// File: hdl/ctp_ifs.sv
// ---------------------------------------------------------------------------
// ctp_ifs
// Valid/ready channels: character words in, timestamp words out.
// ---------------------------------------------------------------------------
interface ctp_in_if import ctp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface ctp_out_if import ctp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_us;
  logic              parse_ok;
  err_t              error_code;

  modport source (output valid, output time_us, output parse_ok, output error_code,
                  input ready);
  modport sink   (input valid, input time_us, input parse_ok, input error_code,
                  output ready);
endinterface

// File: hdl/ctp_parse.sv
// ---------------------------------------------------------------------------
// ctp_parse
// Per-character field accumulation and error latching; hands finished tags on.
// ---------------------------------------------------------------------------
module ctp_parse import ctp_pkg::*; #(
  parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ctp_in_if.sink                 in_ch,
  output logic                   f_valid,
  input  logic                   f_ready,
  output logic [FIELD_WIDTH-1:0] f_min,
  output logic [FIELD_WIDTH-1:0] f_sec,
  output logic [FRAC_W-1:0]      f_frac,
  output logic [FDIG_W-1:0]      f_fdig,
  output err_t                   f_code
);

  localparam int ACC_W = FIELD_WIDTH + 4;

  typedef enum logic [1:0] {
    PH_MIN  = 2'd0,
    PH_SEC  = 2'd1,
    PH_FRAC = 2'd2
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [FIELD_WIDTH-1:0] min_r, min_nxt, sec_r, sec_nxt;
  logic                   seen_r, seen_nxt;
  logic [FRAC_W-1:0]      frac_r, frac_nxt;
  logic [FDIG_W-1:0]      fdig_r, fdig_nxt;
  err_t                   err_r, err_nxt, code_nxt;

  logic                   f_valid_r;
  logic [FIELD_WIDTH-1:0] f_min_r, f_sec_r;
  logic [FRAC_W-1:0]      f_frac_r;
  logic [FDIG_W-1:0]      f_fdig_r;
  err_t                   f_code_r;

  logic                   accept, digit;
  logic [3:0]             dval;
  logic [ACC_W-1:0]       min_ext, sec_ext;
  logic                   min_ovf, sec_ovf;

  assign in_ch.ready = !f_valid_r || f_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign digit       = (in_ch.char_code >= CH_0) && (in_ch.char_code <= CH_9);
  assign dval        = digit ? 4'(in_ch.char_code - CH_0) : 4'd0;

  // acc*10 + d with saturation detect
  assign min_ext = (ACC_W'(min_r) << 3) + (ACC_W'(min_r) << 1) + ACC_W'(dval);
  assign sec_ext = (ACC_W'(sec_r) << 3) + (ACC_W'(sec_r) << 1) + ACC_W'(dval);
  assign min_ovf = |min_ext[ACC_W-1:FIELD_WIDTH];
  assign sec_ovf = |sec_ext[ACC_W-1:FIELD_WIDTH];

  always_comb begin
    phase_nxt = phase_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    seen_nxt  = seen_r;
    frac_nxt  = frac_r;
    fdig_nxt  = fdig_r;
    err_nxt   = err_r;
    unique case (phase_r)
      PH_MIN: begin
        if (digit) begin
          min_nxt = min_ovf ? '1 : min_ext[FIELD_WIDTH-1:0];
          if (min_ovf) err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
        end else if (in_ch.char_code == CH_COLON) begin
          phase_nxt = PH_SEC;
        end else begin
          err_nxt = latch_err(err_nxt, ERR_BAD_CHAR);
        end
      end
      PH_SEC: begin
        if (digit) begin
          sec_nxt  = sec_ovf ? '1 : sec_ext[FIELD_WIDTH-1:0];
          seen_nxt = 1'b1;
          if (sec_ovf) err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
        end else if (in_ch.char_code == CH_DOT || in_ch.char_code == CH_COLON) begin
          if (!seen_r) err_nxt = latch_err(err_nxt, ERR_EMPTY_SEC);
          phase_nxt = PH_FRAC;
        end else begin
          err_nxt = latch_err(err_nxt, ERR_BAD_CHAR);
        end
      end
      PH_FRAC: begin
        if (digit) begin
          if (fdig_r < FDIG_W'(FRAC_KEEP)) begin
            frac_nxt = (frac_r << 3) + (frac_r << 1) + FRAC_W'(dval);
            fdig_nxt = fdig_r + 1'b1;
          end
        end else begin
          err_nxt = latch_err(err_nxt, ERR_BAD_CHAR);
        end
      end
      default: phase_nxt = PH_MIN;
    endcase

    code_nxt = err_nxt;
    if (phase_nxt == PH_MIN) begin
      code_nxt = ERR_NO_COLON;
    end else begin
      if (phase_nxt == PH_SEC && !seen_nxt) code_nxt = latch_err(code_nxt, ERR_EMPTY_SEC);
      if (phase_nxt == PH_FRAC && fdig_nxt == '0) code_nxt = latch_err(code_nxt, ERR_EMPTY_FRC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MIN;
      min_r     <= '0;
      sec_r     <= '0;
      seen_r    <= 1'b0;
      frac_r    <= '0;
      fdig_r    <= '0;
      err_r     <= ERR_NONE;
      f_valid_r <= 1'b0;
    end else begin
      if (accept && in_ch.is_last) begin
        f_valid_r <= 1'b1;
      end else if (f_ready) begin
        f_valid_r <= 1'b0;
      end
      if (accept) begin
        if (in_ch.is_last) begin
          phase_r   <= PH_MIN;
          min_r     <= '0;
          sec_r     <= '0;
          seen_r    <= 1'b0;
          frac_r    <= '0;
          fdig_r    <= '0;
          err_r     <= ERR_NONE;
        end else begin
          phase_r <= phase_nxt;
          min_r   <= min_nxt;
          sec_r   <= sec_nxt;
          seen_r  <= seen_nxt;
          frac_r  <= frac_nxt;
          fdig_r  <= fdig_nxt;
          err_r   <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.is_last) begin
      f_min_r  <= min_nxt;
      f_sec_r  <= sec_nxt;
      f_frac_r <= frac_nxt;
      f_fdig_r <= fdig_nxt;
      f_code_r <= code_nxt;
    end
  end

  assign f_valid = f_valid_r;
  assign f_min   = f_min_r;
  assign f_sec   = f_sec_r;
  assign f_frac  = f_frac_r;
  assign f_fdig  = f_fdig_r;
  assign f_code  = f_code_r;

endmodule

// File: hdl/ctp_time.sv
// ---------------------------------------------------------------------------
// ctp_time
// Two-stage conversion of parsed fields to microseconds, with output register.
// ---------------------------------------------------------------------------
module ctp_time import ctp_pkg::*; #(
  parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   f_valid,
  output logic                   f_ready,
  input  logic [FIELD_WIDTH-1:0] f_min,
  input  logic [FIELD_WIDTH-1:0] f_sec,
  input  logic [FRAC_W-1:0]      f_frac,
  input  logic [FDIG_W-1:0]      f_fdig,
  input  err_t                   f_code,
  ctp_out_if.source              out_ch
);

  localparam int BASE_W = FIELD_WIDTH + 7;
  localparam int PROD_W = (BASE_W + FRAC_US_W > TIME_W) ? BASE_W + FRAC_US_W : TIME_W + 1;

  logic              m_valid_r;
  logic [BASE_W-1:0] m_base_r, m_base_nxt;
  logic [FRAC_US_W-1:0] m_fus_r, m_fus_nxt;
  err_t              m_code_r;

  logic              o_valid_r;
  logic [TIME_W-1:0] o_time_r;
  logic              o_ok_r;
  err_t              o_code_r;

  logic              o_free, m_free;
  logic [PROD_W-1:0] prod;
  logic              t_ovf;
  err_t              code_nxt;

  assign o_free  = !o_valid_r || out_ch.ready;
  assign m_free  = !m_valid_r || o_free;
  assign f_ready = m_free;

  assign m_base_nxt = BASE_W'(f_min) * BASE_W'(SEC_PER_MIN) + BASE_W'(f_sec);
  assign m_fus_nxt  = FRAC_US_W'(f_frac * frac_scale_us(f_fdig));

  assign prod     = PROD_W'(m_base_r) * PROD_W'(US_PER_S) + PROD_W'(m_fus_r);
  assign t_ovf    = |prod[PROD_W-1:TIME_W];
  assign code_nxt = (m_code_r == ERR_NONE && t_ovf) ? ERR_OVERFLOW : m_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (m_free) m_valid_r <= f_valid;
      if (o_free) o_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m_free && f_valid) begin
      m_base_r <= m_base_nxt;
      m_fus_r  <= m_fus_nxt;
      m_code_r <= f_code;
    end
    if (o_free && m_valid_r) begin
      o_time_r <= (code_nxt == ERR_NONE) ? prod[TIME_W-1:0] : '0;
      o_ok_r   <= (code_nxt == ERR_NONE);
      o_code_r <= code_nxt;
    end
  end

  assign out_ch.valid      = o_valid_r;
  assign out_ch.time_us    = o_time_r;
  assign out_ch.parse_ok   = o_ok_r;
  assign out_ch.error_code = o_code_r;

endmodule

// File: hdl/clock_timestamp_text_parser_core.sv
// ---------------------------------------------------------------------------
// clock_timestamp_text_parser_core
// Parses clock tag text (mm:ss[.fff] or mm:ss:ff) into microseconds.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch takes one ASCII character per word, is_last marking the final
//   character of a tag. One word is taken every cycle while in_ch.ready is
//   high; ready depends only on the downstream stages, never on the payload.
//   out_ch gives one word per tag: time_us, parse_ok and error_code
//   (time_us is zero whenever parse_ok is low).
//   A finished tag passes the hand-over register, the conversion stage and
//   the output register, which drives out_ch.valid. Throughput is one
//   character per cycle while in_ch.ready is high, set by the single
//   accumulate step per character; three result words may be in flight.
//   When out_ch stalls, the output register, the conversion stage and the
//   hand-over register fill in turn and hold their words; once all three
//   are full, in_ch.ready drops and no character is taken until out_ch
//   takes a word.
//   Reset (rst_n low, synchronous) empties all stages and returns the
//   parser to the start of a tag.
// ---------------------------------------------------------------------------
module clock_timestamp_text_parser_core import ctp_pkg::*; #(
  parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ctp_in_if.sink    in_ch,
  ctp_out_if.source out_ch
);

  logic                   f_valid, f_ready;
  logic [FIELD_WIDTH-1:0] f_min, f_sec;
  logic [FRAC_W-1:0]      f_frac;
  logic [FDIG_W-1:0]      f_fdig;
  err_t                   f_code;

  ctp_parse #(.FIELD_WIDTH(FIELD_WIDTH)) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_min   (f_min),
    .f_sec   (f_sec),
    .f_frac  (f_frac),
    .f_fdig  (f_fdig),
    .f_code  (f_code)
  );

  ctp_time #(.FIELD_WIDTH(FIELD_WIDTH)) u_time (
    .clk     (clk),
    .rst_n   (rst_n),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_min   (f_min),
    .f_sec   (f_sec),
    .f_frac  (f_frac),
    .f_fdig  (f_fdig),
    .f_code  (f_code),
    .out_ch  (out_ch)
  );

endmodule

// File: bench/tb_clock_timestamp_text_parser_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_clock_timestamp_text_parser_core
// Streams clock tags one character per word, both well-formed and corrupted,
// through bursty input and a stalling receiver. A cycle-free predictor
// computes the expected timestamp word per tag. Output words are compared
// field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_clock_timestamp_text_parser_core;
  import ctp_pkg::*;

  localparam int          RANDOM_CHARS = 1400;
  localparam int          IDLE_LIMIT   = 3000;
  localparam int unsigned FIELD_LIMIT  = (1 << FIELD_WIDTH_DEF) - 1;
  localparam longint unsigned TIME_CAP = (64'd1 << TIME_W) - 1;

  typedef enum logic [1:0] {TAG_MIN, TAG_SEC, TAG_FRAC} tag_phase_t;
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_CADENCE} rdy_mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic              parse_ok;
    err_t              err;
  } stamp_t;

  logic clk;
  logic rst_n;

  ctp_in_if  in_if ();
  ctp_out_if out_if ();

  clock_timestamp_text_parser_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  char_word_t char_q[$];
  stamp_t     stamp_q[$];

  tag_phase_t  tag_phase = TAG_MIN;
  int unsigned min_val   = 0;
  int unsigned sec_val   = 0;
  int unsigned frac_val  = 0;
  int unsigned frac_cnt  = 0;
  bit          sec_seen  = 0;
  err_t        tag_err   = ERR_NONE;

  int        mismatches   = 0;
  int        chars_queued = 0;
  int        chars_taken  = 0;
  int        stamps_seen  = 0;
  int        err_tally[8] = '{default: 0};
  logic      in_taken     = 1'b0;
  int        burst_left   = 0;
  int        gap_left     = 0;
  int        hold_left    = 0;
  bit        held_long    = 0;
  int        seg_left     = 0;
  rdy_mode_t rdy_mode     = RDY_ALWAYS;
  int        idle_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- tag predictor ----
  function automatic err_t merge_err(err_t held, err_t fresh);
    return (held == ERR_NONE || (held == ERR_OVERFLOW && fresh != ERR_OVERFLOW)) ? fresh : held;
  endfunction

  task automatic accumulate(inout int unsigned acc, input int unsigned d);
    acc = acc * 10 + d;
    if (acc > FIELD_LIMIT) begin
      acc     = FIELD_LIMIT;
      tag_err = merge_err(tag_err, ERR_OVERFLOW);
    end
  endtask

  task automatic advance_tag(input logic [CHAR_W-1:0] c, input logic last);
    bit              is_dig;
    int unsigned     d;
    int unsigned     scale;
    err_t            code;
    longint unsigned total;
    stamp_t          s;
    is_dig = (c >= CH_0) && (c <= CH_9);
    d      = is_dig ? int'(c - CH_0) : 0;
    case (tag_phase)
      TAG_MIN: begin
        if (is_dig) accumulate(min_val, d);
        else if (c == CH_COLON) tag_phase = TAG_SEC;
        else tag_err = merge_err(tag_err, ERR_BAD_CHAR);
      end
      TAG_SEC: begin
        if (is_dig) begin
          accumulate(sec_val, d);
          sec_seen = 1'b1;
        end else if (c == CH_DOT || c == CH_COLON) begin
          if (!sec_seen) tag_err = merge_err(tag_err, ERR_EMPTY_SEC);
          tag_phase = TAG_FRAC;
        end else begin
          tag_err = merge_err(tag_err, ERR_BAD_CHAR);
        end
      end
      default: begin
        if (!is_dig) begin
          tag_err = merge_err(tag_err, ERR_BAD_CHAR);
        end else if (frac_cnt < FRAC_KEEP) begin
          frac_val = frac_val * 10 + d;
          frac_cnt++;
        end
      end
    endcase
    if (last) begin
      if (tag_phase == TAG_MIN) begin
        code = ERR_NO_COLON;
      end else begin
        if (tag_phase == TAG_SEC && !sec_seen) tag_err = merge_err(tag_err, ERR_EMPTY_SEC);
        if (tag_phase == TAG_FRAC && frac_cnt == 0) tag_err = merge_err(tag_err, ERR_EMPTY_FRC);
        code = tag_err;
      end
      total = 0;
      if (code == ERR_NONE) begin
        case (frac_cnt)
          1:       scale = 100;
          2:       scale = 10;
          default: scale = 1;
        endcase
        total = (64'(min_val) * SEC_PER_MIN + sec_val) * US_PER_S
              + 64'(frac_val) * scale * US_PER_MS;
        if (total > TIME_CAP) begin
          code  = ERR_OVERFLOW;
          total = 0;
        end
      end
      s.time_us  = total[TIME_W-1:0];
      s.parse_ok = (code == ERR_NONE);
      s.err      = code;
      stamp_q.insert(stamp_q.size(), s);
      err_tally[code]++;
      tag_phase = TAG_MIN;
      min_val   = 0;
      sec_val   = 0;
      frac_val  = 0;
      frac_cnt  = 0;
      sec_seen  = 1'b0;
      tag_err   = ERR_NONE;
    end
  endtask

  // ---- stimulus ----
  task automatic queue_char(input logic [CHAR_W-1:0] c, input logic last);
    char_word_t w;
    w.code = c;
    w.last = last;
    char_q.insert(char_q.size(), w);
    chars_queued++;
  endtask

  task automatic queue_tag(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      queue_char(txt[i], i == txt.len() - 1);
    end
  endtask

  task automatic queue_random_tag();
    logic [CHAR_W-1:0] txt[$];
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // pure noise
      n = $urandom_range(1, 8);
      repeat (n) txt.insert(txt.size(), CHAR_W'($urandom_range(0, 255)));
    end else begin
      roll = $urandom_range(0, 99);
      n = (roll < 10) ? 0 : (roll < 88) ? $urandom_range(1, 2) : $urandom_range(3, 6);
      repeat (n) txt.insert(txt.size(), CHAR_W'(CH_0 + $urandom_range(0, 9)));
      if ($urandom_range(0, 19) != 0) txt.insert(txt.size(), CH_COLON);
      roll = $urandom_range(0, 99);
      n = (roll < 5) ? 0 : (roll < 88) ? $urandom_range(1, 2) : $urandom_range(3, 6);
      repeat (n) txt.insert(txt.size(), CHAR_W'(CH_0 + $urandom_range(0, 9)));
      roll = $urandom_range(0, 3);
      if (roll != 0) begin
        txt.insert(txt.size(), (roll == 3) ? CH_COLON : CH_DOT);
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        repeat (n) txt.insert(txt.size(), CHAR_W'(CH_0 + $urandom_range(0, 9)));
      end
      if (txt.size() == 0) txt.insert(txt.size(), CHAR_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 6) == 0) begin
        txt[$urandom_range(0, txt.size() - 1)] = CHAR_W'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 12) == 0) txt.insert($urandom_range(0, txt.size()), CH_DOT);
    end
    foreach (txt[i]) queue_char(txt[i], i == txt.size() - 1);
  endtask

  initial begin
    int start_chars;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.char_code  = '0;
    in_if.is_last    = 1'b0;
    out_if.ready     = 1'b0;

    queue_tag(":5");
    queue_tag("5");
    queue_char(8'hFF, 1'b0);
    queue_tag(":1");
    queue_tag(":");
    queue_tag("1:2.");
    queue_tag("99999:0");
    queue_char(8'h00, 1'b1);
    queue_tag(":1.2345");
    start_chars = chars_queued;
    while (chars_queued - start_chars < RANDOM_CHARS) queue_random_tag();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (char_q.size() > 0 || in_if.valid || stamp_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d characters in %0d tags checked, %0d parsed clean",
             chars_taken, stamps_seen, err_tally[ERR_NONE]);
    $display("errors: no colon %0d, bad char %0d, empty sec %0d, empty frac %0d, overflow %0d",
             err_tally[ERR_NO_COLON], err_tally[ERR_BAD_CHAR], err_tally[ERR_EMPTY_SEC],
             err_tally[ERR_EMPTY_FRC], err_tally[ERR_OVERFLOW]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---- character driver: bursts with gaps ----
  always @(negedge clk) begin : drv
    char_word_t w;
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (char_q.size() > 0) begin
        w = char_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.char_code <= w.code;
        in_if.is_last   <= w.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---- receiver stall pattern, with one long hold-off ----
  always @(negedge clk) begin : rcv
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (!held_long && stamps_seen >= 30) begin
        held_long    <= 1'b1;
        hold_left    <= 400;
        out_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left <= $urandom_range(10, 80);
          rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
        end else begin
          seg_left <= seg_left - 1;
        end
        case (rdy_mode)
          RDY_ALWAYS: out_if.ready <= 1'b1;
          RDY_HALF:   out_if.ready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:    out_if.ready <= (seg_left % 3 != 0);
        endcase
      end
    end
  end

  // ---- monitor and scoreboard ----
  always @(posedge clk) begin : mon
    stamp_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        chars_taken++;
        advance_tag(in_if.char_code, in_if.is_last);
      end
      in_taken <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        stamps_seen++;
        if (stamp_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word time_us %0d ok %0d err %0d", $time,
                   out_if.time_us, out_if.parse_ok, out_if.error_code);
        end else begin
          want = stamp_q.pop_front();
          if (out_if.time_us !== want.time_us) begin
            mismatches++;
            $display("%0t: time_us expected %0d, got %0d", $time, want.time_us, out_if.time_us);
          end
          if (out_if.parse_ok !== want.parse_ok) begin
            mismatches++;
            $display("%0t: parse_ok expected %0d, got %0d", $time, want.parse_ok,
                     out_if.parse_ok);
          end
          if (out_if.error_code !== want.err) begin
            mismatches++;
            $display("%0t: error_code expected %0d, got %0d", $time, want.err,
                     out_if.error_code);
          end
        end
      end
    end else begin
      in_taken <= 1'b0;
    end
  end

  // ---- watchdog on handshake activity ----
  always @(posedge clk) begin : wdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d words outstanding", $time,
               idle_cycles, stamp_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
